// File: hdl/sbl_pkg.sv
// Shared constants and types for the 3x3 Sobel gradient unit.
// No dependencies; sbl_kernel and sobel_gradient_3x3_unit import this package.
`default_nettype none

package sbl_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Row limit of a frame, independent of the line length.
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

    localparam int GRAD_BITS    = 11;
    localparam int CFG_BITS     = 11;
    localparam int REG_IDX_BITS = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic                RESET_DIRECTION = 1'b0;
    localparam logic [CFG_BITS-1:0] RESET_WIDTH     = 11'd64;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT    = 11'd64;

    // Which neighbor rows/columns of the window lie inside the image.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } sbl_mask_t;

endpackage

`default_nettype wire

// File: hdl/sbl_line_ram.sv
// Line store RAM: one write port, one registered read port, write-through on collision.
// Depends on nothing but its parameters.
`default_nettype none

module sbl_line_ram #(
    parameter int DATA_BITS = 16,
    parameter int DEPTH     = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [DATA_BITS-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic      [DATA_BITS-1:0]         rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] mem_q_reg;
    logic                 fwd_reg;
    logic [DATA_BITS-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Same-edge write to the address being read: hand the new word through.
    always_ff @(posedge aclk) begin
        fwd_reg      <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg <= wr_data;
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// File: hdl/sbl_kernel.sv
// Sobel kernel: masked 3x3 window to a saturated signed gradient.
// Depends on sbl_pkg for the mask type and the gradient width.
`default_nettype none

module sbl_kernel
    import sbl_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic [PIXEL_BITS-1:0]       win [3][3],
    input  wire sbl_mask_t                   mask,
    input  wire logic                        direction,
    output logic signed [GRAD_BITS-1:0]      gradient
);

    localparam int SUM_BITS  = PIXEL_BITS + 2;
    localparam int DIFF_BITS = SUM_BITS + 1;
    localparam int EXT_BITS  = (DIFF_BITS > GRAD_BITS) ? DIFF_BITS : GRAD_BITS;
    localparam logic signed [EXT_BITS-1:0] GRAD_MAX = EXT_BITS'((1 << (GRAD_BITS - 1)) - 1);
    localparam logic signed [EXT_BITS-1:0] GRAD_MIN = -GRAD_MAX - EXT_BITS'(1);

    logic [PIXEL_BITS-1:0] pm [3][3];
    logic [PIXEL_BITS-1:0] pos0, pos1, pos2, neg0, neg1, neg2;
    logic [SUM_BITS-1:0]   pos_sum, neg_sum;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [EXT_BITS-1:0]  diff_ext;

    // Zero the neighbors that fall outside the image.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if ((k == 0 && !mask.top) || (k == 2 && !mask.bottom) ||
                    (j == 0 && !mask.left) || (j == 2 && !mask.right)) begin
                    pm[k][j] = '0;
                end else begin
                    pm[k][j] = win[k][j];
                end
            end
        end
    end

    always_comb begin
        if (direction) begin
            pos0 = pm[0][2]; pos1 = pm[1][2]; pos2 = pm[2][2];
            neg0 = pm[0][0]; neg1 = pm[1][0]; neg2 = pm[2][0];
        end else begin
            pos0 = pm[2][0]; pos1 = pm[2][1]; pos2 = pm[2][2];
            neg0 = pm[0][0]; neg1 = pm[0][1]; neg2 = pm[0][2];
        end
        pos_sum  = SUM_BITS'(pos0) + {1'b0, pos1, 1'b0} + SUM_BITS'(pos2);
        neg_sum  = SUM_BITS'(neg0) + {1'b0, neg1, 1'b0} + SUM_BITS'(neg2);
        diff     = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
        diff_ext = EXT_BITS'(diff);
        if (diff_ext > GRAD_MAX) begin
            gradient = GRAD_MAX[GRAD_BITS-1:0];
        end else if (diff_ext < GRAD_MIN) begin
            gradient = GRAD_MIN[GRAD_BITS-1:0];
        end else begin
            gradient = diff_ext[GRAD_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hdl/sobel_gradient_3x3_unit.sv
// Streaming 3x3 Sobel gradient: one pixel item per cycle while the output is not stalled.
// An item completing a window loads the window stage, then the result register when free;
// results trail the pixel stream by image_width+1 items (flush items push out the tail).
// The line store is a single-port-write RAM read ahead at the next column, so no item waits.
// Reset (aresetn low, synchronous) clears positions, window, valid flags and config;
// the line RAM is not cleared and needs no clearing pass.
`default_nettype none

module sobel_gradient_3x3_unit
    import sbl_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [REG_IDX_BITS-1:0]     cfg_addr,
    input  wire logic [CFG_BITS-1:0]         cfg_wdata,
    // pixel items
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [PIXEL_BITS-1:0]       s_pixel_value,
    input  wire logic                        s_flush_tick,
    // gradient items
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [GRAD_BITS-1:0]      m_gradient,
    output logic                             m_frame_last
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WB        = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (WB > CFG_BITS) ? WB : CFG_BITS;
    localparam int WORD_BITS = 2 * PIXEL_BITS;

    // configuration
    logic                direction_reg;
    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic                geom_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= RESET_DIRECTION;
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DIRECTION:    direction_reg <= cfg_wdata[0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign geom_wr = cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT);

    // clamped geometry, minus one
    logic [CW-1:0]       w_ext, w_m1_wide;
    logic [COL_BITS-1:0] w_m1;
    logic [CFG_BITS-1:0] h_m1_wide;
    logic [ROW_BITS-1:0] h_m1;

    always_comb begin
        w_ext = CW'(width_reg);
        if (width_reg == '0) begin
            w_m1_wide = '0;
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_m1_wide = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1_wide = w_ext - CW'(1);
        end
        if (height_reg == '0) begin
            h_m1_wide = '0;
        end else if (height_reg > CFG_BITS'(HEIGHT_LIMIT)) begin
            h_m1_wide = CFG_BITS'(HEIGHT_LIMIT - 1);
        end else begin
            h_m1_wide = height_reg - CFG_BITS'(1);
        end
    end

    assign w_m1 = w_m1_wide[COL_BITS-1:0];
    assign h_m1 = h_m1_wide[ROW_BITS-1:0];

    // positions; the input row only needs to count to two
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [1:0]          in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_col_reg, out_col_next;
    logic [ROW_BITS-1:0] out_row_reg, out_row_next;

    // stage 1 (window) and output handshake
    logic       s1_valid_reg, s1_valid_next;
    sbl_mask_t  s1_mask_reg, mask_now;
    logic       s1_last_reg;
    logic       out_free, accept, ignore, step, primed, last_now;

    assign out_free = !m_valid || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign ignore   = s_flush_tick && (in_row_reg == 2'd0) && (in_col_reg == '0);
    assign step     = accept && !ignore;
    assign primed   = (in_row_reg == 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
    assign last_now = (out_row_reg == h_m1) && (out_col_reg == w_m1);

    always_comb begin
        mask_now.top    = out_row_reg != '0;
        mask_now.bottom = out_row_reg != h_m1;
        mask_now.left   = out_col_reg != '0;
        mask_now.right  = out_col_reg != w_m1;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (geom_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (step) begin
            if (in_col_reg == w_m1) begin
                in_col_next = '0;
                in_row_next = (in_row_reg == 2'd2) ? 2'd2 : in_row_reg + 2'd1;
            end else begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
            if (primed) begin
                if (last_now) begin
                    // frame done: the next pixel starts a new frame
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_reg == w_m1) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_BITS'(1);
                end else begin
                    out_col_next = out_col_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (step) begin
            s1_valid_next = primed;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            s1_mask_reg <= mask_now;
            s1_last_reg <= last_now;
        end
    end

    // line store: word holds {two rows up, one row up} for each column
    logic [WORD_BITS-1:0]  line_word, line_wr_word;
    logic [PIXEL_BITS-1:0] pixel_in, up1, up2;

    assign pixel_in     = s_flush_tick ? '0 : s_pixel_value;
    assign up1          = line_word[PIXEL_BITS-1:0];
    assign up2          = line_word[WORD_BITS-1:PIXEL_BITS];
    assign line_wr_word = {up1, pixel_in};

    // read ahead at the column the next item will use
    sbl_line_ram #(
        .DATA_BITS (WORD_BITS),
        .DEPTH     (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (in_col_reg),
        .wr_data (line_wr_word),
        .rd_addr (in_col_next),
        .rd_data (line_word)
    );

    // 3x3 window, column 2 is the newest
    logic [PIXEL_BITS-1:0] win_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (step) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= up2;
            win_reg[1][2] <= up1;
            win_reg[2][2] <= pixel_in;
        end
    end

    logic signed [GRAD_BITS-1:0] grad_comb;

    sbl_kernel #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .win       (win_reg),
        .mask      (s1_mask_reg),
        .direction (direction_reg),
        .gradient  (grad_comb)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            m_gradient   <= grad_comb;
            m_frame_last <= s1_last_reg;
        end
    end

    // checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |-> !s_ready)
        else $error("window stage accepted an item while its result was stalled");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && primed && last_now |=> in_col_reg == '0 && in_row_reg == 2'd0
            && out_col_reg == '0 && out_row_reg == '0)
        else $error("positions not cleared after the last item of a frame");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_col_reg <= w_m1 && out_col_reg <= w_m1)
        else $error("column position beyond the image width");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s1_valid_reg))
        else $error("result presented without a filled window stage");

endmodule

`default_nettype wire
